// ----- rtl/fpls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpls_pkg
// Shared types and constants for the fixed-point line stepper.
// ----------------------------------------------------------------------------
package fpls_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic signed [COORD_BITS-1:0]  x_start;
        logic signed [COORD_BITS-1:0]  y_start;
        logic signed [COORD_BITS-1:0]  x_end;
        logic signed [COORD_BITS-1:0]  y_end;
    } req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pix_x;
        logic signed [COORD_BITS-1:0]  pix_y;
        logic                          pix_valid;
        logic                          pix_last;
    } res_t;

endpackage

// ----- rtl/fixed_point_line_stepper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_line_stepper_core
// DDA line rasterizer: a start request sets up the line and emits the first
// pixel, each step request emits the next pixel.
// ----------------------------------------------------------------------------
// Output: every request writes its result into the output register on
// acceptance.
// Throughput: step requests 1 per cycle while the output is not stalled; a start
// request with a nonzero major length keeps the block busy while the restoring
// divider forms the slope, one quotient bit per cycle.
// Reset (aresetn low, synchronous): no line active, divider idle, output empty.
module fixed_point_line_stepper_core #(
    parameter int FRAC_BITS = fpls_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fpls_pkg::req_t  s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output fpls_pkg::res_t  m_res
);

    localparam int CB         = fpls_pkg::COORD_BITS;
    localparam int ACC_BITS   = CB + FRAC_BITS + 2;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t                 state_reg;
    logic [CB-1:0]          major_pos_reg;
    logic [CB-1:0]          major_end_reg;
    logic [ACC_BITS-1:0]    minor_accum_reg;
    logic [SLOPE_BITS-1:0]  slope_step_reg;
    logic                   step_down_reg;
    logic                   y_is_major_reg;
    logic                   line_active_reg;
    logic [CB:0]            rem_reg;
    logic [CB-1:0]          divisor_reg;
    logic [Q_BITS-1:0]      quot_reg;
    logic                   slope_neg_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   m_valid_reg;
    fpls_pkg::res_t         m_res_reg;

    logic                   accept;
    logic signed [CB:0]     dx;
    logic signed [CB:0]     dy;
    logic [CB:0]            adx_full;
    logic [CB:0]            ady_full;
    logic [CB-1:0]          adx;
    logic [CB-1:0]          ady;
    logic                   y_major;
    logic [CB-1:0]          st_pos;
    logic [CB-1:0]          st_end;
    logic [CB-1:0]          st_minor;
    logic [CB-1:0]          st_amaj;
    logic [CB-1:0]          st_amin;
    logic                   st_down;
    logic                   st_neg;
    logic [ACC_BITS-1:0]    st_accum;
    logic [CB-1:0]          sp_pos;
    logic [ACC_BITS-1:0]    sp_accum;
    logic [CB-1:0]          sp_minor;
    logic                   sp_last;
    logic [CB:0]            div_diff;
    logic                   div_bit;
    logic [CB:0]            div_rem;
    logic [Q_BITS-1:0]      quot_next;
    logic [SLOPE_BITS-1:0]  q_ext;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // start setup
    always_comb begin
        dx       = {s_req.x_end[CB-1], s_req.x_end} - {s_req.x_start[CB-1], s_req.x_start};
        dy       = {s_req.y_end[CB-1], s_req.y_end} - {s_req.y_start[CB-1], s_req.y_start};
        adx_full = dx[CB] ? ((CB+1)'(0) - dx) : dx;
        ady_full = dy[CB] ? ((CB+1)'(0) - dy) : dy;
        adx      = adx_full[CB-1:0];
        ady      = ady_full[CB-1:0];
        y_major  = ady > adx;
        if (y_major) begin
            st_pos   = s_req.y_start;
            st_end   = s_req.y_end;
            st_minor = s_req.x_start;
            st_amaj  = ady;
            st_amin  = adx;
            st_down  = dy[CB];
            st_neg   = dx[CB];
        end else begin
            st_pos   = s_req.x_start;
            st_end   = s_req.x_end;
            st_minor = s_req.y_start;
            st_amaj  = adx;
            st_amin  = ady;
            st_down  = dx[CB];
            st_neg   = dy[CB];
        end
        st_accum = {{2{st_minor[CB-1]}}, st_minor, {FRAC_BITS{1'b0}}}
                 | (ACC_BITS'(1) << (FRAC_BITS - 1));
    end

    // step datapath
    always_comb begin
        sp_pos   = major_pos_reg + (step_down_reg ? {CB{1'b1}} : CB'(1));
        sp_accum = minor_accum_reg
                 + {{(ACC_BITS-SLOPE_BITS){slope_step_reg[SLOPE_BITS-1]}}, slope_step_reg};
        sp_minor = sp_accum[FRAC_BITS +: CB];
        sp_last  = sp_pos == major_end_reg;
    end

    // one restoring divide step
    always_comb begin
        div_diff  = rem_reg - {1'b0, divisor_reg};
        div_bit   = rem_reg >= {1'b0, divisor_reg};
        div_rem   = div_bit ? div_diff : rem_reg;
        quot_next = {quot_reg[Q_BITS-2:0], div_bit};
        q_ext     = {1'b0, quot_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !accept) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        m_valid_reg <= 1'b1;
                        if (s_req.op == fpls_pkg::OP_START) begin
                            major_pos_reg   <= st_pos;
                            major_end_reg   <= st_end;
                            minor_accum_reg <= st_accum;
                            step_down_reg   <= st_down;
                            y_is_major_reg  <= y_major;
                            line_active_reg <= st_amaj != '0;
                            slope_step_reg  <= '0;
                            rem_reg         <= {1'b0, st_amin};
                            divisor_reg     <= st_amaj;
                            slope_neg_reg   <= st_neg;
                            quot_reg        <= '0;
                            cnt_reg         <= CNT_BITS'(FRAC_BITS);
                            m_res_reg.pix_x     <= s_req.x_start;
                            m_res_reg.pix_y     <= s_req.y_start;
                            m_res_reg.pix_valid <= 1'b1;
                            m_res_reg.pix_last  <= st_amaj == '0;
                            if (st_amaj != '0) begin
                                state_reg <= ST_DIV;
                            end
                        end else if (line_active_reg) begin
                            major_pos_reg   <= sp_pos;
                            minor_accum_reg <= sp_accum;
                            line_active_reg <= !sp_last;
                            m_res_reg.pix_x     <= y_is_major_reg ? sp_minor : sp_pos;
                            m_res_reg.pix_y     <= y_is_major_reg ? sp_pos : sp_minor;
                            m_res_reg.pix_valid <= 1'b1;
                            m_res_reg.pix_last  <= sp_last;
                        end else begin
                            m_res_reg <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg  <= {div_rem[CB-1:0], 1'b0};
                    quot_reg <= quot_next;
                    cnt_reg  <= cnt_reg - CNT_BITS'(1);
                    if (cnt_reg == '0) begin
                        slope_step_reg <= slope_neg_reg ? (SLOPE_BITS'(0) - q_ext) : q_ext;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
